// ===== hw/rtl/lfsr_ks_pkg.sv =====
// Shared types and constants for the LFSR keystream core.
// No dependencies; imported by every module of the block.
package lfsr_ks_pkg;

   localparam int KIND_W  = 2;
   localparam int SEED_W  = 64;
   localparam int VALUE_W = 8;
   localparam int LEN_W   = 7;
   localparam int TAP_W   = 64;
   localparam int CSR_IDX_W = 2;
   localparam int STEPS_PER_BYTE = 8;
   localparam int MIN_LENGTH = 2;
   localparam int RESET_LENGTH = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD = 2'd0,
      KIND_BIT  = 2'd1,
      KIND_BYTE = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REG_LENGTH = 2'd0,
      CSR_TAP_MASK   = 2'd1
   } csr_index_type;

endpackage

// ===== hw/rtl/lfsr_ks_csr.sv =====
// Configuration registers: clamped length, tap mask, derived seed mask
// and feedback insertion select. Depends on lfsr_ks_pkg.
module lfsr_ks_csr
   import lfsr_ks_pkg::*;
#(
   parameter int MAX_LENGTH = 64,
   localparam int LW = $clog2(MAX_LENGTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [TAP_W-1:0]      csr_wdata,
   output logic [MAX_LENGTH-1:0] tap_mask,
   output logic [MAX_LENGTH-1:0] len_mask,
   output logic [MAX_LENGTH-1:0] ins_sel
);

   function automatic logic [LW-1:0] clamp_len(input logic [LEN_W-1:0] raw);
      logic [LEN_W-1:0] v;
      v = raw;
      if (v < LEN_W'(MIN_LENGTH)) v = LEN_W'(MIN_LENGTH);
      if (v > LEN_W'(MAX_LENGTH)) v = LEN_W'(MAX_LENGTH);
      return LW'(v);
   endfunction

   function automatic logic [MAX_LENGTH-1:0] mask_of(input logic [LW-1:0] len);
      logic [MAX_LENGTH-1:0] m;
      for (int i = 0; i < MAX_LENGTH; i++) m[i] = (i < int'(len));
      return m;
   endfunction

   function automatic logic [MAX_LENGTH-1:0] sel_of(input logic [LW-1:0] len);
      logic [MAX_LENGTH-1:0] s;
      for (int i = 0; i < MAX_LENGTH; i++) s[i] = ((i + 1) == int'(len));
      return s;
   endfunction

   localparam logic [LW-1:0] RESET_LEN = clamp_len(LEN_W'(RESET_LENGTH));

   logic [MAX_LENGTH-1:0] tap_ff,  tap_in;
   logic [MAX_LENGTH-1:0] mask_ff, mask_in;
   logic [MAX_LENGTH-1:0] sel_ff,  sel_in;
   logic [LW-1:0]         new_len;

   assign new_len = clamp_len(csr_wdata[LEN_W-1:0]);

   always_comb begin
      tap_in  = tap_ff;
      mask_in = mask_ff;
      sel_in  = sel_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_REG_LENGTH: begin
               mask_in = mask_of(new_len);
               sel_in  = sel_of(new_len);
            end
            CSR_TAP_MASK: begin
               tap_in = csr_wdata[MAX_LENGTH-1:0];
            end
            default: begin
               tap_in = tap_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff  <= '0;
         mask_ff <= mask_of(RESET_LEN);
         sel_ff  <= sel_of(RESET_LEN);
      end else begin
         tap_ff  <= tap_in;
         mask_ff <= mask_in;
         sel_ff  <= sel_in;
      end
   end

   assign tap_mask = tap_ff;
   assign len_mask = mask_ff;
   assign ins_sel  = sel_ff;

endmodule

// ===== hw/rtl/lfsr_ks_step.sv =====
// Next-state and result logic for one item: seed load, one step or
// eight chained LFSR steps. Depends on lfsr_ks_pkg.
module lfsr_ks_step
   import lfsr_ks_pkg::*;
#(
   parameter int MAX_LENGTH = 64
) (
   input  logic [KIND_W-1:0]     kind,
   input  logic [MAX_LENGTH-1:0] seed,
   input  logic [MAX_LENGTH-1:0] state,
   input  logic [MAX_LENGTH-1:0] tap_mask,
   input  logic [MAX_LENGTH-1:0] len_mask,
   input  logic [MAX_LENGTH-1:0] ins_sel,
   output logic [MAX_LENGTH-1:0] state_nxt,
   output logic [VALUE_W-1:0]    value
);

   logic [MAX_LENGTH-1:0]     chain [0:STEPS_PER_BYTE];
   logic [STEPS_PER_BYTE-1:0] bits;
   logic [STEPS_PER_BYTE-1:0] fb;
   logic [VALUE_W-1:0]        byte_val;

   always_comb begin
      chain[0] = state;
      for (int k = 0; k < STEPS_PER_BYTE; k++) begin
         bits[k]    = chain[k][0];
         fb[k]      = ^(chain[k] & tap_mask);
         chain[k+1] = (chain[k] >> 1) | ({MAX_LENGTH{fb[k]}} & ins_sel);
      end
      for (int k = 0; k < STEPS_PER_BYTE; k++) byte_val[VALUE_W-1-k] = bits[k];
   end

   always_comb begin
      unique case (kind)
         KIND_LOAD: begin
            state_nxt = seed & len_mask;
            value     = '0;
         end
         KIND_BIT: begin
            state_nxt = chain[1];
            value     = {{(VALUE_W-1){1'b0}}, bits[0]};
         end
         KIND_BYTE: begin
            state_nxt = chain[STEPS_PER_BYTE];
            value     = byte_val;
         end
         default: begin
            state_nxt = state;
            value     = '0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/fibonacci_lfsr_keystream_core.sv =====
// Top level of the Fibonacci LFSR keystream core.
// Depends on lfsr_ks_pkg, lfsr_ks_csr and lfsr_ks_step.
//
// Usage:
//  - req_* carries one item: req_kind (0 load seed, 1 next bit, 2 next byte)
//    and req_seed. An item is taken when req_valid is high and req_stall low.
//  - rsp_* returns exactly one rsp_value per item, in order, taken when
//    rsp_valid is high and rsp_stall low.
//  - csr_* writes register 0 (length, clamped to 2..MAX_LENGTH) or register 1
//    (tap mask); csr_ready is always high. Write only while the core is idle.
//  - Pipeline: an item is taken into the input register; its result is then
//    registered in the output register, which drives rsp_*.
//  - Throughput: one item per cycle while rsp_stall holds no waiting result;
//    the eight chained shift steps of a byte item are combinational.
//  - Stall: while rsp_stall holds a waiting result, the input register keeps
//    one more item and then req_stall rises; nothing is dropped.
//  - Reset: clears the shift state, the valid bits of both pipeline registers,
//    the tap mask and sets the length to 16.
module fibonacci_lfsr_keystream_core
   import lfsr_ks_pkg::*;
#(
   parameter int MAX_LENGTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [SEED_W-1:0]    req_seed,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [VALUE_W-1:0]   rsp_value,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TAP_W-1:0]     csr_wdata
);

   logic [MAX_LENGTH-1:0] tap_mask;
   logic [MAX_LENGTH-1:0] len_mask;
   logic [MAX_LENGTH-1:0] ins_sel;

   logic                  s1_valid_ff, s1_valid_in;
   logic [KIND_W-1:0]     s1_kind_ff;
   logic [MAX_LENGTH-1:0] s1_seed_ff;
   logic [MAX_LENGTH-1:0] state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                  out_adv;
   logic                  s1_adv;
   logic                  req_take;

   assign csr_ready = 1'b1;

   lfsr_ks_csr #(.MAX_LENGTH(MAX_LENGTH)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .tap_mask  (tap_mask),
      .len_mask  (len_mask),
      .ins_sel   (ins_sel)
   );

   lfsr_ks_step #(.MAX_LENGTH(MAX_LENGTH)) u_step (
      .kind      (s1_kind_ff),
      .seed      (s1_seed_ff),
      .state     (state_ff),
      .tap_mask  (tap_mask),
      .len_mask  (len_mask),
      .ins_sel   (ins_sel),
      .state_nxt (state_in),
      .value     (rsp_value_in)
   );

   assign out_adv      = !rsp_valid_ff || !rsp_stall;
   assign s1_adv       = s1_valid_ff && out_adv;
   assign req_stall    = s1_valid_ff && !out_adv;
   assign req_take     = req_valid && !req_stall;
   assign s1_valid_in  = req_stall ? 1'b1 : req_valid;
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff <= req_kind;
         s1_seed_ff <= req_seed[MAX_LENGTH-1:0];
      end
      if (s1_adv) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty input register");

   a_rsp_from_adv: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_adv))
      else $error("result appeared without an item advancing");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_adv |=> $stable(state_ff))
      else $error("shift state changed without an item");

   a_bit_upper_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_kind_ff == KIND_BIT) |=> (rsp_value_ff[VALUE_W-1:1] == '0))
      else $error("bit item returned nonzero upper bits");

   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_kind_ff != KIND_BIT && s1_kind_ff != KIND_BYTE)
         |=> (rsp_value_ff == '0))
      else $error("load or unused item returned nonzero value");

endmodule
